[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define CHLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define CHLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/chlc_pkg.sv]
// ---------------------------------------------------------------------------
// chlc_pkg
// Types and constants of the ClientHello legacy field checker.
// ---------------------------------------------------------------------------
package chlc_pkg;

  localparam int LENGTH_BITS = 24;
  // byte position counter width, independent of the kept length bits
  localparam int POS_W       = 25;
  localparam int CPOS_W      = 17;
  localparam int SID_W       = 6;

  localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HDR_LAST_POS   = POS_W'(3);
  localparam logic [POS_W-1:0] HDR_BYTES      = POS_W'(4);
  localparam logic [POS_W-1:0] VER_HI_IDX     = POS_W'(0);
  localparam logic [POS_W-1:0] VER_LO_IDX     = POS_W'(1);
  localparam logic [POS_W-1:0] SID_LEN_IDX    = POS_W'(34);
  localparam logic [POS_W-1:0] SID_BODY_START = POS_W'(35);

  localparam logic [7:0]       MSG_CLIENT_HELLO = 8'd1;
  localparam logic [7:0]       LEGACY_VER_BYTE  = 8'h03;
  localparam logic [7:0]       SID_MAX          = 8'd32;
  localparam logic [7:0]       COMP_COUNT_ONE   = 8'd1;
  localparam logic [7:0]       COMP_NULL        = 8'd0;
  localparam logic [CPOS_W-1:0] COMP_BASE       = CPOS_W'(37);
  localparam logic [SID_W-1:0] SID_MSG_OFFSET   = SID_W'(39);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } chlc_step_t;

  typedef struct packed {
    logic             legacy_ok;
    logic             sid_found;
    logic [SID_W-1:0] sid_length;
    logic [SID_W-1:0] sid_start;
  } chlc_result_t;

  typedef struct packed {
    logic cnull;
    logic ccnt;
    logic cpos;
    logic ver;
  } chlc_flags_t;

endpackage

[rtl/chlc_if.sv]
// ---------------------------------------------------------------------------
// chlc_in_if / chlc_out_if
// Valid/ready channels for message bytes and check results.
// ---------------------------------------------------------------------------
interface chlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chlc_out_if;
  import chlc_pkg::*;
  logic             valid;
  logic             ready;
  logic             legacy_ok;
  logic             sid_found;
  logic [SID_W-1:0] sid_length;
  logic [SID_W-1:0] sid_start;

  modport source (output valid, output legacy_ok, output sid_found,
                  output sid_length, output sid_start, input ready);
  modport sink   (input valid, input legacy_ok, input sid_found,
                  input sid_length, input sid_start, output ready);
endinterface

[rtl/chlc_in_stage.sv]
// ---------------------------------------------------------------------------
// chlc_in_stage
// Input register: holds one byte request until the parser takes it.
// ---------------------------------------------------------------------------
module chlc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  chlc_in_if.sink             req_i,
  input  logic                advance_i,
  output logic                step_valid_o,
  output chlc_pkg::chlc_step_t step_o
);
  import chlc_pkg::*;

  logic       valid_q, valid_d;
  chlc_step_t step_q, step_d;
  logic       take;

  assign req_i.ready = !valid_q || advance_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    step_d  = step_q;
    if (take) begin
      valid_d          = 1'b1;
      step_d.data_byte = req_i.data_byte;
      step_d.last_byte = req_i.last_byte;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  assign step_valid_o = valid_q;
  assign step_o       = step_q;

endmodule

[rtl/chlc_parser.sv]
// ---------------------------------------------------------------------------
// chlc_parser
// Per-byte parse state of the handshake message and the final verdict.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chlc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_valid_i,
  input  chlc_pkg::chlc_step_t  step_i,
  output chlc_pkg::chlc_result_t result_o
);
  import chlc_pkg::*;

  logic [POS_W-1:0]       pos_q, pos_d;
  logic [7:0]             type_q, type_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [7:0]             sl_q, sl_d;
  logic [CPOS_W-1:0]      cpos_q, cpos_d;
  logic [7:0]             suh_q, suh_d;
  chlc_flags_t            flags_q, flags_d;

  logic [7:0]                 v;
  logic [POS_W-1:0]           idx;
  logic [POS_W-1:0]           len_ext;
  logic [POS_W-1:0]           sl_ext;
  logic [POS_W-1:0]           cpos_ext;
  logic [LENGTH_BITS+7:0]     len_shift;
  logic [POS_W:0]             need_cnt;
  logic [POS_W:0]             sid_end;
  logic                       in_body;
  logic                       hdr_ok, sid_ok, leg_ok;

  assign v         = step_i.data_byte;
  assign idx       = pos_q - HDR_BYTES;
  assign len_ext   = POS_W'(len_q);
  assign sl_ext    = POS_W'(sl_q);
  assign cpos_ext  = POS_W'(cpos_q);
  assign len_shift = {len_q, v};
  assign in_body   = (pos_q >= HDR_BYTES) && (idx < len_ext);

  always_comb begin
    type_d  = type_q;
    len_d   = len_q;
    sl_d    = sl_q;
    cpos_d  = cpos_q;
    suh_d   = suh_q;
    flags_d = flags_q;
    pos_d   = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
    if (pos_q == '0) begin
      type_d = v;
    end else if (pos_q <= HDR_LAST_POS) begin
      len_d = len_shift[LENGTH_BITS-1:0];
    end else if (in_body) begin
      if (idx == VER_HI_IDX) begin
        if (v == LEGACY_VER_BYTE) flags_d.ver = 1'b1;
      end else if (idx == VER_LO_IDX) begin
        if (v != LEGACY_VER_BYTE) flags_d.ver = 1'b0;
      end else if (idx == SID_LEN_IDX) begin
        sl_d = v;
      end else if (idx >= SID_BODY_START && sl_q <= SID_MAX) begin
        if (idx == SID_BODY_START + sl_ext) begin
          suh_d = v;
        end else if (idx == SID_BODY_START + sl_ext + POS_W'(1)) begin
          // compression count sits right after the skipped cipher suites
          cpos_d       = COMP_BASE + CPOS_W'(sl_q) + CPOS_W'({suh_q, v});
          flags_d.cpos = 1'b1;
        end else if (flags_q.cpos) begin
          if (idx == cpos_ext) begin
            if (v == COMP_COUNT_ONE) flags_d.ccnt = 1'b1;
          end else if (idx == cpos_ext + POS_W'(1)) begin
            if (flags_q.ccnt && v == COMP_NULL) flags_d.cnull = 1'b1;
          end
        end
      end
    end
  end

  // verdict uses the state as updated by the last byte
  always_comb begin
    need_cnt = (POS_W+1)'(len_d) + (POS_W+1)'(HDR_LAST_POS);
    sid_end  = (POS_W+1)'(SID_BODY_START) + (POS_W+1)'(sl_d);
    hdr_ok   = ((POS_W+1)'(pos_q) >= need_cnt) && (type_d == MSG_CLIENT_HELLO);
    sid_ok   = hdr_ok && (sl_d <= SID_MAX) && (sid_end <= (POS_W+1)'(len_d));
    leg_ok   = sid_ok && flags_d.ver && flags_d.cnull;
    result_o.legacy_ok  = leg_ok;
    result_o.sid_found  = sid_ok;
    result_o.sid_length = sid_ok ? sl_d[SID_W-1:0] : '0;
    result_o.sid_start  = sid_ok ? SID_MSG_OFFSET : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      sl_q    <= '0;
      cpos_q  <= '0;
      suh_q   <= '0;
      flags_q <= '0;
    end else if (step_valid_i) begin
      if (step_i.last_byte) begin
        // message done, next byte opens a new one
        pos_q   <= '0;
        type_q  <= '0;
        len_q   <= '0;
        sl_q    <= '0;
        cpos_q  <= '0;
        suh_q   <= '0;
        flags_q <= '0;
      end else begin
        pos_q   <= pos_d;
        type_q  <= type_d;
        len_q   <= len_d;
        sl_q    <= sl_d;
        cpos_q  <= cpos_d;
        suh_q   <= suh_d;
        flags_q <= flags_d;
      end
    end
  end

  `CHLC_ASSERT(a_last_clears_pos, step_valid_i && step_i.last_byte |=> pos_q == '0, "position not cleared after last byte")
  `CHLC_ASSERT(a_cnull_needs_ccnt, flags_q.cnull |-> flags_q.ccnt && flags_q.cpos, "null method flag without count flag")

endmodule

[rtl/client_hello_legacy_checker.sv]
// ---------------------------------------------------------------------------
// client_hello_legacy_checker
// Legacy field check of a TLS 1.3 ClientHello handshake message.
// ---------------------------------------------------------------------------
// Usage:
//   req_i carries the message one byte per request, with last_byte set on
//   its final byte. res_o carries one result per message, issued for the
//   request that has last_byte set; other bytes give no result.
//   A last byte accepted on req_i sits in the input register while the
//   parser works, then the result register loads and res_o shows the
//   result. Throughput: one byte per cycle, sustained while no final byte
//   waits; each byte is one pass of the parser compares and updates.
//   Reset clears the valid flags of the input and result registers and the
//   parse state; the first byte after reset opens a new message.
//   When res_o is stalled, bytes that are not final keep flowing into the
//   parser; a final byte waits in the input register until the result
//   register is free, and req_i.ready drops while it waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module client_hello_legacy_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  chlc_in_if.sink     req_i,
  chlc_out_if.source  res_o
);
  import chlc_pkg::*;

  logic         step_valid;
  chlc_step_t   step;
  chlc_result_t result;
  logic         out_free;
  logic         advance;
  logic         load;

  logic         res_valid_q, res_valid_d;
  chlc_result_t res_q;

  assign out_free = !res_valid_q || res_o.ready;
  assign advance  = step_valid && (!step.last_byte || out_free);
  assign load     = advance && step.last_byte;

  chlc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .advance_i    (advance),
    .step_valid_o (step_valid),
    .step_o       (step)
  );

  chlc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (advance),
    .step_i       (step),
    .result_o     (result)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.legacy_ok  = res_q.legacy_ok;
  assign res_o.sid_found  = res_q.sid_found;
  assign res_o.sid_length = res_q.sid_length;
  assign res_o.sid_start  = res_q.sid_start;

  `CHLC_ASSERT(a_load_sets_valid, load |=> res_valid_q, "result lost after final byte")
  `CHLC_ASSERT(a_valid_from_load, $rose(res_valid_q) |-> $past(load), "result without final byte")
  `CHLC_ASSERT(a_held_byte_stays, step_valid && !advance |=> step_valid && $stable(step), "held byte changed while waiting")
  `CHLC_ASSERT_ALWAYS(a_no_load_when_busy, load |-> out_free, "result register overwritten")

endmodule
